// File: hdl/pfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_pkg: shared types and constants of the page framebuffer blitter
// Action codes, register indexes, beat structs and controller/datapath links.
// ----------------------------------------------------------------------------
package pfb_pkg;

	localparam int unsigned STORE_BYTES_DEF = 1024;
	localparam int unsigned PIX_ADDR_W      = 12;
	localparam int unsigned CFG_IDX_W       = 1;
	localparam int unsigned CFG_DATA_W      = 8;

	localparam logic [2:0] ACT_PUT        = 3'd0;
	localparam logic [2:0] ACT_START_BLIT = 3'd1;
	localparam logic [2:0] ACT_BLIT_BYTE  = 3'd2;
	localparam logic [2:0] ACT_CLEAR      = 3'd3;
	localparam logic [2:0] ACT_FILL       = 3'd4;
	localparam logic [2:0] ACT_READ       = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

	localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
	localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

	typedef struct packed {
		logic [2:0] action;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic       pixel_color;
		logic [7:0] bitmap_width;
		logic [7:0] bitmap_height;
		logic [7:0] bitmap_byte;
		logic [9:0] read_index;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       blit_done;
	} result_t;

	typedef struct packed {
		logic accept;
		logic sweep;
		logic init;
		logic pixel;
		logic read;
		logic finish;
	} dp_cmd_t;

	typedef struct packed {
		logic blit_live;
		logic sweep_last;
		logic step_last;
		logic out_free;
	} dp_sts_t;

endpackage
`default_nettype wire

// File: hdl/pfb_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_ctrl: blitter sequencer
// One-hot state machine that steps the datapath through one action at a time.
// ----------------------------------------------------------------------------
module pfb_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	input  wire logic [2:0]       action,
	output logic                  item_stall,
	input  wire pfb_pkg::dp_sts_t sts,
	output pfb_pkg::dp_cmd_t      cmd
);

	typedef enum logic [6:0] {
		ST_INIT   = 7'b0000001,
		ST_IDLE   = 7'b0000010,
		ST_SWEEP  = 7'b0000100,
		ST_PIXEL  = 7'b0001000,
		ST_DRAIN  = 7'b0010000,
		ST_READ   = 7'b0100000,
		ST_FINISH = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				if (sts.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (item_valid) begin
					case (action)
						pfb_pkg::ACT_PUT:       state_d = ST_PIXEL;
						pfb_pkg::ACT_BLIT_BYTE: state_d = sts.blit_live ? ST_PIXEL : ST_FINISH;
						pfb_pkg::ACT_CLEAR:     state_d = ST_SWEEP;
						pfb_pkg::ACT_FILL:      state_d = ST_SWEEP;
						pfb_pkg::ACT_READ:      state_d = ST_READ;
						default:                state_d = ST_FINISH;
					endcase
				end
			end
			ST_SWEEP: begin
				if (sts.sweep_last) state_d = ST_FINISH;
			end
			ST_PIXEL: begin
				if (sts.step_last) state_d = ST_DRAIN;
			end
			ST_DRAIN:  state_d = ST_FINISH;
			ST_READ:   state_d = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else         state_q <= state_d;
	end

	assign item_stall = (state_q != ST_IDLE);

	always_comb begin
		cmd        = '0;
		cmd.accept = (state_q == ST_IDLE) && item_valid;
		cmd.sweep  = (state_q == ST_INIT) || (state_q == ST_SWEEP);
		cmd.init   = (state_q == ST_INIT);
		cmd.pixel  = (state_q == ST_PIXEL);
		cmd.read   = (state_q == ST_READ);
		cmd.finish = (state_q == ST_FINISH) && sts.out_free;
	end

endmodule
`default_nettype wire

// File: hdl/pfb_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfb_dpath: blitter datapath
// Frame store, pixel address unit, read-modify-write pipe, blit cursor,
// configuration registers and result register.
// ----------------------------------------------------------------------------
module pfb_dpath #(
	parameter int unsigned STORE_BYTES = pfb_pkg::STORE_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire pfb_pkg::item_t                 item,
	input  wire pfb_pkg::dp_cmd_t               cmd,
	output pfb_pkg::dp_sts_t                    sts,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output pfb_pkg::result_t                    result
);

	localparam int unsigned AW = $clog2(STORE_BYTES);
	localparam int unsigned CW = ((AW > pfb_pkg::PIX_ADDR_W) ? AW : pfb_pkg::PIX_ADDR_W) + 1;
	localparam logic [CW-1:0] STORE_LIMIT = CW'(STORE_BYTES);
	localparam logic [AW-1:0] SWEEP_LAST  = AW'(STORE_BYTES - 1);

	logic [7:0]       fw_q;
	logic [6:0]       fh_q;
	pfb_pkg::item_t   item_q;
	logic [7:0]       org_x_q, org_y_q, size_w_q, size_h_q, col_q, row_q;
	logic             color_q;
	logic [2:0]       k_q;
	logic [AW-1:0]    sweep_cnt_q;
	logic             pix_v_s1;
	logic [AW-1:0]    pix_addr_s1;
	logic [7:0]       pix_mask_s1;
	logic             pix_color_s1;
	logic [7:0]       mem [STORE_BYTES];
	logic [7:0]       mem_rd_q;
	logic             result_valid_q;
	pfb_pkg::result_t result_q;

	logic                          blit_live, is_put, blit_step, row_end, done;
	logic [10:0]                   off, base;
	logic [pfb_pkg::PIX_ADDR_W-1:0] px_w, page_ofs;
	logic [8:0]                    py_w;
	logic                          bit_en, in_frame, pix_ok, pix_color;
	logic [3:0]                    page;
	logic [CW-1:0]                 addr_full, ridx_full;
	logic [7:0]                    pix_mask, row_next;
	logic                          sweep_last, out_free;
	logic                          rd_en, wr_en;
	logic [AW-1:0]                 rd_addr, wr_addr;
	logic [7:0]                    wr_data;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= pfb_pkg::FRAME_WIDTH_RST;
			fh_q <= pfb_pkg::FRAME_HEIGHT_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				pfb_pkg::REG_FRAME_WIDTH:  fw_q <= cfg_data;
				pfb_pkg::REG_FRAME_HEIGHT: fh_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
	end

	// pixel address unit
	assign blit_live = (size_w_q != 8'd0) && (row_q < size_h_q);
	assign is_put    = (item_q.action == pfb_pkg::ACT_PUT);
	assign base      = {col_q, 3'b000};
	assign off       = base + {8'd0, k_q};
	assign px_w      = is_put ? {4'd0, item_q.pos_x} : ({4'd0, org_x_q} + {1'b0, off});
	assign py_w      = is_put ? {1'b0, item_q.pos_y} : ({1'b0, org_y_q} + {1'b0, row_q});
	assign bit_en    = is_put || (item_q.bitmap_byte[~k_q] && (off < {3'd0, size_w_q}));
	assign in_frame  = (px_w < {4'd0, fw_q}) && (py_w < {2'd0, fh_q});
	assign page      = py_w[6:3];
	assign page_ofs  = {8'd0, page} * {4'd0, fw_q};
	assign addr_full = CW'(px_w[7:0]) + CW'(page_ofs);
	assign pix_ok    = bit_en && in_frame && (addr_full < STORE_LIMIT);
	assign pix_mask  = 8'd1 << py_w[2:0];
	assign pix_color = is_put ? item_q.pixel_color : color_q;
	assign ridx_full = CW'(item_q.read_index);

	// frame store access
	assign rd_en   = (cmd.pixel && pix_ok) || cmd.read;
	assign rd_addr = cmd.read ? ridx_full[AW-1:0] : addr_full[AW-1:0];
	assign wr_en   = cmd.sweep || pix_v_s1;
	assign wr_addr = cmd.sweep ? sweep_cnt_q : pix_addr_s1;
	always_comb begin
		if (cmd.sweep)
			wr_data = (!cmd.init && (item_q.action == pfb_pkg::ACT_FILL)) ? 8'hFF : 8'h00;
		else if (pix_color_s1)
			wr_data = mem_rd_q & ~pix_mask_s1;
		else
			wr_data = mem_rd_q | pix_mask_s1;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) mem_rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		pix_addr_s1  <= addr_full[AW-1:0];
		pix_mask_s1  <= pix_mask;
		pix_color_s1 <= pix_color;
	end

	assign sweep_last = (sweep_cnt_q == SWEEP_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_v_s1    <= 1'b0;
			k_q         <= 3'd0;
			sweep_cnt_q <= '0;
		end else begin
			pix_v_s1 <= cmd.pixel && pix_ok;
			if (cmd.accept)     k_q <= 3'd0;
			else if (cmd.pixel) k_q <= k_q + 3'd1;
			if (cmd.sweep) sweep_cnt_q <= sweep_last ? '0 : sweep_cnt_q + AW'(1);
		end
	end

	// blit cursor
	assign blit_step = (item_q.action == pfb_pkg::ACT_BLIT_BYTE) && blit_live;
	assign row_end   = ({1'b0, base} + 12'd8) >= {4'd0, size_w_q};
	assign row_next  = row_q + 8'd1;
	assign done      = blit_step && row_end && (row_next == size_h_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q  <= 8'd0;
			org_y_q  <= 8'd0;
			size_w_q <= 8'd0;
			size_h_q <= 8'd0;
			col_q    <= 8'd0;
			row_q    <= 8'd0;
			color_q  <= 1'b0;
		end else if (cmd.accept && (item.action == pfb_pkg::ACT_START_BLIT)) begin
			org_x_q  <= item.pos_x;
			org_y_q  <= item.pos_y;
			size_w_q <= item.bitmap_width;
			size_h_q <= item.bitmap_height;
			color_q  <= item.pixel_color;
			col_q    <= 8'd0;
			row_q    <= 8'd0;
		end else if (cmd.finish && blit_step) begin
			if (row_end) begin
				col_q <= 8'd0;
				row_q <= row_next;
			end else begin
				col_q <= col_q + 8'd1;
			end
		end
	end

	// result register
	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)         result_valid_q <= 1'b0;
		else if (cmd.finish) result_valid_q <= 1'b1;
		else if (!result_stall) result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.read_data <= ((item_q.action == pfb_pkg::ACT_READ) &&
			                       (ridx_full < STORE_LIMIT)) ? mem_rd_q : 8'd0;
			result_q.blit_done <= done;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_comb begin
		sts            = '0;
		sts.blit_live  = blit_live;
		sts.sweep_last = sweep_last;
		sts.step_last  = is_put || (k_q == 3'd7);
		sts.out_free   = out_free;
	end

endmodule
`default_nettype wire

// File: hdl/page_framebuffer_pixel_blitter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// page_framebuffer_pixel_blitter: monochrome page framebuffer with blitter
// Top level: sequencer plus datapath around a single-port-write frame store.
// ----------------------------------------------------------------------------
// Works on one item at a time; item_stall stays high until the item's result
// is in the output register. A blit byte makes at most one frame store read
// per bitmap bit, with each write following its read in the next cycle; with
// no blit open it goes straight to the result, as do start blit and unused
// actions. Clear and fill write one store byte per cycle. After reset the
// block clears the store before taking its first item; configuration writes
// are taken throughout.
module page_framebuffer_pixel_blitter #(
	parameter int unsigned STORE_BYTES = pfb_pkg::STORE_BYTES_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_write,
	input  wire logic [pfb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [pfb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire logic                           item_valid,
	output logic                                item_stall,
	input  wire pfb_pkg::item_t                 item,
	output logic                                result_valid,
	input  wire logic                           result_stall,
	output pfb_pkg::result_t                    result
);

	pfb_pkg::dp_cmd_t cmd;
	pfb_pkg::dp_sts_t sts;

	pfb_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.action     (item.action),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	pfb_dpath #(
		.STORE_BYTES (STORE_BYTES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	a_sweep_blocks_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.sweep |-> item_stall)
		else $error("store sweep overlaps item accept");

	a_one_store_op: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.sweep, cmd.pixel, cmd.read, cmd.finish}))
		else $error("more than one store operation in a cycle");

	a_finish_shows_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid)
		else $error("finished item did not produce a result beat");

	a_done_xor_data: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.blit_done && (result.read_data != 8'd0)))
		else $error("result carries both blit done and read data");

endmodule
`default_nettype wire
